@@ src/assert_macros.svh @@
// Assertion macros for the checker module of the leaf table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/slt_pkg.sv @@
// Package for the sorted leaf table: field widths, codes and cell interface types.
`timescale 1ns / 1ps

package slt_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DEF_ROW_BITS = 64;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned ROW_FIELD_W = 64;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned STATUS_W    = 2;

  localparam logic KIND_FIND   = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } slt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_EMIT
  } slt_state_e;

  // Command from the sequencer to one cell.
  typedef struct packed {
    logic shift;  // take the left neighbor's contents
    logic load;   // take the new key and payload
  } cell_ctl_t;

  // Compare flags from one cell against the search key.
  typedef struct packed {
    logic eq;     // search key equals the stored key
    logic lt;     // search key below the stored key
  } cell_flag_t;

endpackage

@@ src/sorted_leaf_table.sv @@
// Top level of the sorted leaf table: a chain of key/payload cells and its sequencer.
`timescale 1ns / 1ps

// sorted_leaf_table holds one B-tree leaf as a chain of CAPACITY cells, each with a
// 32-bit key and a ROW_BITS-bit payload, kept in key order by the user. A find
// transaction binary-searches the stored keys and returns status 0 with the hit index
// and its payload, or status 1 with the lower-bound insertion point and a zero
// payload; with duplicate keys the first cell that the search probes wins. An insert
// transaction writes the key and payload at the given position and moves every cell
// above it up by one in the same cycle; it returns status 2 when the table is full
// and status 3 when the position is beyond the count, and then changes nothing.
// cell_count always reports the number of cells held after the transaction.
// Timing: one transaction at a time. An insert passes through the execute and emit
// states after acceptance before the next transaction can be taken; a find works
// through the search state, at most floor(log2(count)) + 1 binary-search probes, and
// then the emit state. The search sequencer probes one cell compare result per cycle.
// A finished result waits in the output register while the next transaction is
// accepted and worked on; it only delays the block when a second result is ready
// before the first has been taken. Cell storage is not cleared at reset; only cells
// below the count are ever read.
module sorted_leaf_table #(
  parameter int unsigned CAPACITY = slt_pkg::DEF_CAPACITY,
  parameter int unsigned ROW_BITS = slt_pkg::DEF_ROW_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [slt_pkg::KEY_W-1:0]       key_i,
  input  logic [slt_pkg::ROW_FIELD_W-1:0] row_data_i,
  input  logic [slt_pkg::POS_W-1:0]       position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [slt_pkg::STATUS_W-1:0]    status_o,
  output logic [slt_pkg::POS_W-1:0]       found_position_o,
  output logic [slt_pkg::ROW_FIELD_W-1:0] found_row_o,
  output logic [slt_pkg::POS_W-1:0]       cell_count_o
);
  import slt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);

  // Cell chain wiring: contents of each cell, its compare flags and its command.
  logic [KEY_W-1:0]    cell_key  [CAPACITY];
  logic [ROW_BITS-1:0] cell_row  [CAPACITY];
  cell_flag_t          cell_flag [CAPACITY];
  cell_ctl_t           cell_ctl  [CAPACITY];

  logic [IW-1:0]       mid;
  logic [KEY_W-1:0]    item_key;
  logic [ROW_BITS-1:0] item_row;
  logic [ROW_BITS-1:0] mid_row;

  // Payload of the cell under the current probe; used only on a hit.
  assign mid_row = cell_row[mid];

  slt_ctrl #(
    .CAPACITY (CAPACITY),
    .ROW_BITS (ROW_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .key_i            (key_i),
    .row_data_i       (row_data_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .found_row_o      (found_row_o),
    .cell_count_o     (cell_count_o),
    .flags_i          (cell_flag),
    .mid_row_i        (mid_row),
    .ctl_o            (cell_ctl),
    .mid_o            (mid),
    .item_key_o       (item_key),
    .item_row_o       (item_row)
  );

  // Each cell takes from its left neighbor on a shift; cell 0 never shifts, so its
  // left input just repeats the new item.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_W-1:0]    left_key;
    logic [ROW_BITS-1:0] left_row;

    if (g == 0) begin : g_head
      assign left_key = item_key;
      assign left_row = item_row;
    end else begin : g_link
      assign left_key = cell_key[g-1];
      assign left_row = cell_row[g-1];
    end

    slt_cell #(
      .ROW_BITS (ROW_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl[g]),
      .left_key_i   (left_key),
      .left_row_i   (left_row),
      .new_key_i    (item_key),
      .new_row_i    (item_row),
      .search_key_i (item_key),
      .key_o        (cell_key[g]),
      .row_o        (cell_row[g]),
      .flag_o       (cell_flag[g])
    );
  end

endmodule

@@ src/slt_cell.sv @@
// One table cell: key and payload storage, shift from the left, key compare.
`timescale 1ns / 1ps

module slt_cell #(
  parameter int unsigned ROW_BITS = slt_pkg::DEF_ROW_BITS
) (
  input  logic                     clk_i,
  input  slt_pkg::cell_ctl_t       ctl_i,
  input  logic [slt_pkg::KEY_W-1:0] left_key_i,
  input  logic [ROW_BITS-1:0]      left_row_i,
  input  logic [slt_pkg::KEY_W-1:0] new_key_i,
  input  logic [ROW_BITS-1:0]      new_row_i,
  input  logic [slt_pkg::KEY_W-1:0] search_key_i,
  output logic [slt_pkg::KEY_W-1:0] key_o,
  output logic [ROW_BITS-1:0]      row_o,
  output slt_pkg::cell_flag_t      flag_o
);
  import slt_pkg::*;

  logic [KEY_W-1:0]    key_q, key_d;
  logic [ROW_BITS-1:0] row_q, row_d;

  always_comb begin
    key_d = key_q;
    row_d = row_q;
    if (ctl_i.load) begin
      key_d = new_key_i;
      row_d = new_row_i;
    end else if (ctl_i.shift) begin
      key_d = left_key_i;
      row_d = left_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    row_q <= row_d;
  end

  assign key_o     = key_q;
  assign row_o     = row_q;
  assign flag_o.eq = (search_key_i == key_q);
  assign flag_o.lt = (search_key_i < key_q);

endmodule

@@ src/slt_ctrl.sv @@
// Sequencer: transaction handshake, cell count, insert commands, binary search, result register.
`timescale 1ns / 1ps

module slt_ctrl #(
  parameter int unsigned CAPACITY = slt_pkg::DEF_CAPACITY,
  parameter int unsigned ROW_BITS = slt_pkg::DEF_ROW_BITS,
  localparam int unsigned IW = $clog2(CAPACITY)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [slt_pkg::KEY_W-1:0]       key_i,
  input  logic [slt_pkg::ROW_FIELD_W-1:0] row_data_i,
  input  logic [slt_pkg::POS_W-1:0]       position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [slt_pkg::STATUS_W-1:0]    status_o,
  output logic [slt_pkg::POS_W-1:0]       found_position_o,
  output logic [slt_pkg::ROW_FIELD_W-1:0] found_row_o,
  output logic [slt_pkg::POS_W-1:0]       cell_count_o,
  input  slt_pkg::cell_flag_t             flags_i [CAPACITY],
  input  logic [ROW_BITS-1:0]             mid_row_i,
  output slt_pkg::cell_ctl_t              ctl_o [CAPACITY],
  output logic [IW-1:0]                   mid_o,
  output logic [slt_pkg::KEY_W-1:0]       item_key_o,
  output logic [ROW_BITS-1:0]             item_row_o
);
  import slt_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  slt_state_e state_q, state_d;

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          lo_q, lo_d;
  logic [CW-1:0]          hi_q, hi_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [ROW_BITS-1:0]    row_q, row_d;
  logic [POS_W-1:0]       pos_q, pos_d;

  slt_status_e            res_status_q, res_status_d;
  logic [CW-1:0]          res_pos_q, res_pos_d;
  logic [ROW_FIELD_W-1:0] res_row_q, res_row_d;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [POS_W-1:0]       out_pos_q, out_pos_d;
  logic [ROW_FIELD_W-1:0] out_row_q, out_row_d;
  logic [POS_W-1:0]       out_count_q, out_count_d;

  logic [CW:0]   lo_hi_sum;
  logic [IW-1:0] mid;
  logic [CW-1:0] mid_ext;

  assign lo_hi_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = IW'(lo_hi_sum >> 1);
  assign mid_ext   = CW'(mid);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    key_d        = key_q;
    row_d        = row_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_row_d    = res_row_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_row_d    = out_row_q;
    out_count_d  = out_count_q;
    in_stall_o   = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      ctl_o[i] = '0;
    end

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          key_d  = key_i;
          row_d  = row_data_i[ROW_BITS-1:0];
          pos_d  = position_i;
          lo_d   = '0;
          hi_d   = count_q;
          state_d = (kind_i == KIND_INSERT) ? S_EXEC : S_SEARCH;
        end
      end

      S_EXEC: begin
        // Insert: check room and position, then load one cell and shift the ones above.
        res_row_d = '0;
        if (count_q >= CW'(CAPACITY)) begin
          res_status_d = STAT_FULL;
          res_pos_d    = '0;
        end else if (CMPW'(pos_q) > CMPW'(count_q)) begin
          res_status_d = STAT_RANGE;
          res_pos_d    = '0;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            ctl_o[i].load  = (CMPW'(i) == CMPW'(pos_q));
            ctl_o[i].shift = (CMPW'(i) > CMPW'(pos_q));
          end
          count_d      = count_q + 1'b1;
          res_status_d = STAT_OK;
          res_pos_d    = CW'(pos_q);
        end
        state_d = S_EMIT;
      end

      S_SEARCH: begin
        // One probe per cycle; the cells already hold their compare flags.
        if (lo_q < hi_q) begin
          if (flags_i[mid].eq) begin
            res_status_d = STAT_OK;
            res_pos_d    = mid_ext;
            res_row_d    = ROW_FIELD_W'(mid_row_i);
            state_d      = S_EMIT;
          end else if (flags_i[mid].lt) begin
            hi_d = mid_ext;
          end else begin
            lo_d = mid_ext + 1'b1;
          end
        end else begin
          res_status_d = STAT_MISS;
          res_pos_d    = lo_q;
          res_row_d    = '0;
          state_d      = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = POS_W'(res_pos_q);
          out_row_d    = res_row_q;
          out_count_d  = POS_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    key_q        <= key_d;
    row_q        <= row_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_row_q    <= res_row_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_row_q    <= out_row_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_pos_q;
  assign found_row_o      = out_row_q;
  assign cell_count_o     = out_count_q;
  assign mid_o            = mid;
  assign item_key_o       = key_q;
  assign item_row_o       = row_q;

endmodule

@@ src/slt_checker.sv @@
// Port-level checker for the sorted leaf table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slt_checker #(
  parameter int unsigned CAPACITY = slt_pkg::DEF_CAPACITY
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_i,
  input logic                            out_valid_i,
  input logic                            out_stall_i,
  input logic [slt_pkg::STATUS_W-1:0]    status_i,
  input logic [slt_pkg::POS_W-1:0]       found_position_i,
  input logic [slt_pkg::ROW_FIELD_W-1:0] found_row_i,
  input logic [slt_pkg::POS_W-1:0]       cell_count_i
);
  import slt_pkg::*;

  localparam logic [POS_W-1:0] FULL_COUNT = POS_W'(CAPACITY);

  // Whole result payload, and the result conditions the checks key on.
  logic [STATUS_W+2*POS_W+ROW_FIELD_W-1:0] res_word;
  logic                                    out_held;
  logic                                    not_ok;
  logic                                    full_res;
  logic                                    reject;

  assign res_word = {status_i, found_position_i, found_row_i, cell_count_i};
  assign out_held = out_valid_i && out_stall_i;
  assign not_ok   = out_valid_i && (status_i != STAT_OK);
  assign full_res = out_valid_i && (status_i == STAT_FULL);
  assign reject   = out_valid_i && (status_i inside {STAT_FULL, STAT_RANGE});

  // A stalled result holds its payload.
  `SLT_ASSERT_NEXT(a_out_hold, out_held, out_valid_i && $stable(res_word), "stalled result changed")

  // One transaction at a time: the input stalls right after an acceptance.
  `SLT_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_i, in_stall_i, "input taken while busy")

  // A result whose status is not OK carries a zero payload.
  `SLT_ASSERT_NOW(a_row_on_hit, not_ok, found_row_i == '0, "payload on a non-hit")

  // A full report means the table really holds CAPACITY cells.
  `SLT_ASSERT_NOW(a_full_count, full_res, cell_count_i == FULL_COUNT, "full status with room left")

  // A rejected insert reports position zero.
  `SLT_ASSERT_NOW(a_reject_pos, reject, found_position_i == '0, "rejected insert with a position")

endmodule

bind sorted_leaf_table slt_checker #(
  .CAPACITY (CAPACITY)
) u_slt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_i         (status_o),
  .found_position_i (found_position_o),
  .found_row_i      (found_row_o),
  .cell_count_i     (cell_count_o)
);
